// ===== rtl/core/vfd_pkg.sv =====
`default_nettype none

package vfd_pkg;

    localparam int MAX_FRAME_WIDTH  = 1024;
    localparam int MAX_FRAME_HEIGHT = 1024;
    localparam int MAX_FRAME_PIXELS = 262144;
    localparam int HEADER_BYTES     = 16;

    localparam int SCAN_LIMIT = 2 * MAX_FRAME_PIXELS + HEADER_BYTES;
    localparam int SCAN_W     = $clog2(SCAN_LIMIT + HEADER_BYTES + 1);
    localparam int IDX_W      = $clog2(HEADER_BYTES);
    localparam int PIX_W      = $clog2(MAX_FRAME_PIXELS + 1);

    localparam logic [7:0] SYNC_BYTE = 8'hFE;
    localparam logic [7:0] MAX_ROT   = 8'd3;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic RK_PIXEL = 1'b0;
    localparam logic RK_LOST  = 1'b1;

    localparam logic [IDX_W-1:0] HB_WIDTH_HI  = IDX_W'(1);
    localparam logic [IDX_W-1:0] HB_WIDTH_LO  = IDX_W'(2);
    localparam logic [IDX_W-1:0] HB_HEIGHT_HI = IDX_W'(3);
    localparam logic [IDX_W-1:0] HB_HEIGHT_LO = IDX_W'(4);
    localparam logic [IDX_W-1:0] HB_ROT       = IDX_W'(5);
    localparam logic [IDX_W-1:0] HB_DUR_0     = IDX_W'(6);
    localparam logic [IDX_W-1:0] HB_DUR_1     = IDX_W'(7);
    localparam logic [IDX_W-1:0] HB_DUR_2     = IDX_W'(8);
    localparam logic [IDX_W-1:0] HB_DUR_3     = IDX_W'(9);
    localparam logic [IDX_W-1:0] HB_STR_0     = IDX_W'(10);
    localparam logic [IDX_W-1:0] HB_STR_1     = IDX_W'(11);
    localparam logic [IDX_W-1:0] HB_STR_2     = IDX_W'(12);
    localparam logic [IDX_W-1:0] HB_STR_3     = IDX_W'(13);
    localparam logic [IDX_W-1:0] HB_RESTART   = IDX_W'(14);
    localparam logic [IDX_W-1:0] HB_ENCODING = IDX_W'(15);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic        result_kind;
        logic [15:0] pixel_value;
        logic        last_pixel;
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [1:0]  frame_rotation;
        logic [31:0] haptic_duration;
        logic [31:0] haptic_strength;
        logic [7:0]  restart_flag;
        logic [7:0]  encoding_code;
        logic [31:0] frame_number;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/core/video_frame_deframer_unit.sv =====
// Video frame deframer. Received stream bytes enter on the input channel
// (i_in_valid, o_in_stall, i_data_byte), one word per cycle while o_in_stall
// is low. The block hunts for the sync byte, checks the fixed-size header and
// then turns payload byte pairs into 16-bit pixel results carrying the header
// fields and the frame number; a sync-lost result appears when the scan limit
// passes. Results leave on the output channel (o_out_valid, i_out_stall, o_*
// fields). Throughput is one input word per cycle while the result queue is
// not full. A result is written into the four-entry result queue when the
// byte that completes it is accepted, and then moves into the output register.
// While the receiver stalls, the output word holds and the queue fills; once
// the queue is full, o_in_stall rises until a result leaves. Synchronous
// active-low reset returns the parser to the hunt, clears the frame counter
// and empties the queue and output register.
`default_nettype none

module video_frame_deframer_unit
    import vfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [15:0]      o_pixel_value,
    output logic             o_last_pixel,
    output logic [10:0]      o_frame_width,
    output logic [10:0]      o_frame_height,
    output logic [1:0]       o_frame_rotation,
    output logic [31:0]      o_haptic_duration,
    output logic [31:0]      o_haptic_strength,
    output logic [7:0]       o_restart_flag,
    output logic [7:0]       o_encoding_code,
    output logic [31:0]      o_frame_number
);

    logic          accept;
    logic          push;
    logic          pop;
    t_result       front_result;
    t_result       queue_data;
    t_result       out_result;
    t_queue_status status;

    assign o_in_stall = status.full;
    assign accept     = i_in_valid && !status.full;

    vfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_data_byte),
        .o_push   (push),
        .o_result (front_result)
    );

    vfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_result),
        .i_pop    (pop),
        .o_data   (queue_data),
        .o_status (status)
    );

    vfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .i_data   (queue_data),
        .o_pop    (pop),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_result_kind        = out_result.result_kind;
    assign o_pixel_value        = out_result.pixel_value;
    assign o_last_pixel         = out_result.last_pixel;
    assign o_frame_width        = out_result.frame_width;
    assign o_frame_height       = out_result.frame_height;
    assign o_frame_rotation     = out_result.frame_rotation;
    assign o_haptic_duration    = out_result.haptic_duration;
    assign o_haptic_strength    = out_result.haptic_strength;
    assign o_restart_flag       = out_result.restart_flag;
    assign o_encoding_code      = out_result.encoding_code;
    assign o_frame_number       = out_result.frame_number;

endmodule

`default_nettype wire

// ===== rtl/core/vfd_front.sv =====
`default_nettype none

module vfd_front
    import vfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data,
    output logic            o_push,
    output t_result         o_result
);

    logic [1:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [SCAN_W-1:0] r_scan, n_scan;
    logic [PIX_W-1:0] r_left, n_left;
    logic [7:0]       r_high, n_high;
    logic             r_half, n_half;
    logic [31:0]      r_count, n_count;

    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_rot, n_rot;
    logic [31:0] r_dur, n_dur;
    logic [31:0] r_str, n_str;
    logic [7:0]  r_restart, n_restart;
    logic [7:0]  r_enc, n_enc;
    logic [31:0] r_area;

    logic [SCAN_W-1:0] scan_inc;
    logic [IDX_W:0]    idx_inc;
    logic [PIX_W-1:0]  left_dec;
    logic              hdr_ok;
    logic              over_limit;

    assign scan_inc   = r_scan + 1'b1;
    assign idx_inc    = {1'b0, r_idx} + 1'b1;
    assign left_dec   = (r_left != '0) ? r_left - 1'b1 : r_left;
    assign over_limit = (scan_inc >= SCAN_W'(SCAN_LIMIT));
    assign hdr_ok     = (r_width != '0) && (r_height != '0)
                        && (r_width <= 16'(MAX_FRAME_WIDTH))
                        && (r_height <= 16'(MAX_FRAME_HEIGHT))
                        && (r_area <= 32'(MAX_FRAME_PIXELS))
                        && (r_rot <= MAX_ROT);

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_scan    = r_scan;
        n_left    = r_left;
        n_high    = r_high;
        n_half    = r_half;
        n_count   = r_count;
        n_width   = r_width;
        n_height  = r_height;
        n_rot     = r_rot;
        n_dur     = r_dur;
        n_str     = r_str;
        n_restart = r_restart;
        n_enc     = r_enc;
        o_push    = 1'b0;
        o_result  = '0;
        o_result.result_kind = RK_LOST;
        o_result.frame_number = r_count;

        if (i_accept) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    if (!r_half) begin
                        n_high = i_data;
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        n_left = left_dec;
                        o_push = 1'b1;
                        o_result.result_kind        = RK_PIXEL;
                        o_result.pixel_value        = {r_high, i_data};
                        o_result.last_pixel         = (left_dec == '0);
                        o_result.frame_width        = r_width[10:0];
                        o_result.frame_height       = r_height[10:0];
                        o_result.frame_rotation     = r_rot[1:0];
                        o_result.haptic_duration    = r_dur;
                        o_result.haptic_strength    = r_str;
                        o_result.restart_flag       = r_restart;
                        o_result.encoding_code      = r_enc;
                        o_result.frame_number       = r_count + 1'b1;
                        if (left_dec == '0) begin
                            n_count = r_count + 1'b1;
                            n_phase = PH_HUNT;
                            n_scan  = '0;
                        end
                    end
                end
                PH_HEADER: begin
                    n_scan = scan_inc;
                    n_idx  = idx_inc[IDX_W-1:0];
                    case (r_idx)
                        HB_WIDTH_HI:  n_width[15:8]  = i_data;
                        HB_WIDTH_LO:  n_width[7:0]   = i_data;
                        HB_HEIGHT_HI: n_height[15:8] = i_data;
                        HB_HEIGHT_LO: n_height[7:0]  = i_data;
                        HB_ROT:       n_rot          = i_data;
                        HB_DUR_0:     n_dur[31:24]   = i_data;
                        HB_DUR_1:     n_dur[23:16]   = i_data;
                        HB_DUR_2:     n_dur[15:8]    = i_data;
                        HB_DUR_3:     n_dur[7:0]     = i_data;
                        HB_STR_0:     n_str[31:24]   = i_data;
                        HB_STR_1:     n_str[23:16]   = i_data;
                        HB_STR_2:     n_str[15:8]    = i_data;
                        HB_STR_3:     n_str[7:0]     = i_data;
                        HB_RESTART:   n_restart      = i_data;
                        HB_ENCODING:  n_enc          = i_data;
                        default:      n_rot          = n_rot;
                    endcase
                    if (idx_inc == (IDX_W + 1)'(HEADER_BYTES)) begin
                        n_idx = '0;
                        if (hdr_ok) begin
                            n_phase = PH_PAYLOAD;
                            n_left  = r_area[PIX_W-1:0];
                            n_half  = 1'b0;
                            n_scan  = '0;
                        end else begin
                            n_phase = PH_HUNT;
                            if (over_limit) begin
                                o_push = 1'b1;
                                n_scan = '0;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_scan  = scan_inc;
                    if (i_data == SYNC_BYTE) begin
                        n_idx   = IDX_W'(1);
                        n_phase = PH_HEADER;
                    end else if (over_limit) begin
                        o_push = 1'b1;
                        n_scan = '0;
                        n_idx  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_idx   <= '0;
            r_scan  <= '0;
            r_left  <= '0;
            r_half  <= 1'b0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_scan  <= n_scan;
            r_left  <= n_left;
            r_half  <= n_half;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_high    <= n_high;
        r_width   <= n_width;
        r_height  <= n_height;
        r_rot     <= n_rot;
        r_dur     <= n_dur;
        r_str     <= n_str;
        r_restart <= n_restart;
        r_enc     <= n_enc;
        r_area    <= r_width * r_height;
    end

endmodule

`default_nettype wire

// ===== rtl/core/vfd_queue.sv =====
`default_nettype none

module vfd_queue
    import vfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output t_result      o_data,
    output t_queue_status o_status
);

    t_result             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QPTR_W:0]     r_cnt, n_cnt;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vfd_back.sv =====
`default_nettype none

module vfd_back
    import vfd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_queue_status i_status,
    input  wire t_result       i_data,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output t_result            o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_pop    = !i_status.empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

endmodule

`default_nettype wire
